[rtl/core/sine_range_reduced_polynomial_assert.svh]
// Assertion macros shared by the sine pipeline modules.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef SINE_RANGE_REDUCED_POLYNOMIAL_ASSERT_SVH
`define SINE_RANGE_REDUCED_POLYNOMIAL_ASSERT_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge out of reset.
`define SRP_ASSERT_HOLDS(name, clk_sig, rstn_sig, expr) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (expr)) \
        else $error("srp assertion failed");

// A consequent that holds in the same cycle as its antecedent.
`define SRP_ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("srp assertion failed");

// A consequent that holds in the cycle after its antecedent.
`define SRP_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("srp assertion failed");

`else

`define SRP_ASSERT_HOLDS(name, clk_sig, rstn_sig, expr)
`define SRP_ASSERT_IMPLIES(name, clk_sig, rstn_sig, ante, cons)
`define SRP_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons)

`endif

`endif

[rtl/core/srp_pkg.sv]
// Types, fixed-point constants and the rounding helper of the sine pipeline.
// Depends on nothing; imported by every module of the block.
package srp_pkg;

    // Widths of the range reduction datapath.
    localparam int U_W    = 56;   // magnitude in Q.32, below 2^56
    localparam int K_W    = 22;   // turn count
    localparam int KD_W   = 57;   // turn count times the high part of 2pi
    localparam int REM_W  = 36;   // remainder before the final correction
    localparam int R_W    = 37;   // signed remainder in Q.32
    localparam int LO_W   = 50;   // turn count times the low part of 2pi
    localparam int X_W    = 33;   // signed Q.30 polynomial operands
    localparam int PROD_W = 66;   // full Q.60 products
    localparam int OUT_W  = 32;

    // Constants of the range reduction.
    localparam logic [34:0] TWOPI_HI    = 35'h6487ED511;
    localparam logic [27:0] TWOPI_LO    = 28'hB4611A6;
    localparam logic [33:0] PI_Q32      = 34'h3243F6A89;
    localparam logic [32:0] HALF_PI_Q32 = 33'h1921FB544;
    // floor(2^64 / TWOPI_HI), used to estimate the turn count.
    localparam logic [29:0] INV_TWOPI   = 30'h28BE60DB;

    typedef logic signed [X_W-1:0]    q30_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Taylor coefficients in Q.30.
    localparam q30_t ONE_Q30 = 33'sd1073741824;
    localparam q30_t C1_Q30  = 33'sd1073741824;
    localparam q30_t C3_Q30  = -33'sd178956971;
    localparam q30_t C5_Q30  = 33'sd8947849;
    localparam q30_t C7_Q30  = -33'sd213044;
    localparam q30_t C9_Q30  = 33'sd2959;
    localparam q30_t C11_Q30 = -33'sd27;

    // Control that travels with each request down the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } srp_ctl_t;

    // Q.60 product back to Q.30, rounding half away from zero.
    function automatic q30_t rnd_q30(input prod_t v);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] rnd;
        neg = v[PROD_W-1];
        mag = neg ? PROD_W'(-v) : PROD_W'(v);
        rnd = (mag + (PROD_W'(1) << 29)) >> 30;
        return neg ? -q30_t'(rnd[X_W-1:0]) : q30_t'(rnd[X_W-1:0]);
    endfunction

endpackage

[rtl/core/sine_range_reduced_polynomial.sv]
// Fixed-point sine, Q16.16 angle in and Q1.30 sine out; uses srp_pkg, srp_reduce, srp_poly.
// A request passes through thirteen register stages before sine_valid rises
// (five range reduction, eight polynomial), each with at most one multiplier.
// Throughput is one request per cycle; every stage holds while sine_valid waits on sine_ready.
// Reset (rst_n low, asynchronous) clears every stage valid bit; data registers are not reset.

module sine_range_reduced_polynomial #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                angle_valid,
    output logic                angle_ready,
    input  logic signed [31:0]  angle,
    output logic                sine_valid,
    input  logic                sine_ready,
    output logic signed [31:0]  sine
);
    import srp_pkg::*;

    logic     en;
    srp_ctl_t red_ctl;
    q30_t     red_x;
    srp_ctl_t out_ctl;

    // The pipeline advances unless a finished result is waiting.
    assign en          = !sine_valid || sine_ready;
    assign angle_ready = en;

    srp_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_in(angle_valid),
        .angle   (angle),
        .ctl_out (red_ctl),
        .x_out   (red_x)
    );

    srp_poly u_poly (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_in (red_ctl),
        .x_in   (red_x),
        .ctl_out(out_ctl),
        .y_out  (sine)
    );

    assign sine_valid = out_ctl.valid;

endmodule

[rtl/core/srp_reduce.sv]
// Range reduction stages: turn count estimate, remainder, fold into [-pi/2, pi/2].
// Depends on srp_pkg and the assertion macro header.
`include "sine_range_reduced_polynomial_assert.svh"

module srp_reduce #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    valid_in,
    input  logic signed [31:0]      angle,
    output srp_pkg::srp_ctl_t       ctl_out,
    output srp_pkg::q30_t           x_out
);
    import srp_pkg::*;

    localparam int SHIFT = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [R_W-1:0] PI_S      = $signed(R_W'(PI_Q32));
    localparam logic signed [R_W-1:0] HALF_PI_S = $signed(R_W'(HALF_PI_Q32));
    localparam logic signed [R_W-1:0] TOP_S     = $signed(R_W'(TWOPI_HI)) - PI_S;
    localparam q30_t X_LIMIT = q30_t'(HALF_PI_Q32 >> 2);

    srp_ctl_t ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;

    logic [K_W-1:0]          k1_reg, k2_reg, k3_reg;
    logic [U_W-1:0]          v1_reg, v2_reg;
    logic [KD_W-1:0]         kd2_reg;
    logic signed [R_W-1:0]   r03_reg, r04_reg;
    logic [LO_W-1:0]         lo4_reg;
    q30_t                    x5_reg;

    // Stage 1: magnitude, scale to Q.32, estimate the turn count.
    logic           s1_neg;
    logic [31:0]    s1_mag;
    logic [U_W-1:0] s1_u;
    logic [U_W-1:0] s1_v;
    logic [61:0]    s1_kprod;

    always_comb
    begin
        s1_neg   = angle[31];
        s1_mag   = s1_neg ? (~angle + 32'd1) : angle;
        s1_u     = U_W'(s1_mag) << SHIFT;
        s1_v     = s1_u + U_W'(PI_Q32);
        s1_kprod = 62'(s1_v[U_W-1:U_W-32]) * 62'(INV_TWOPI);
    end

    // Stage 3: remainder and one-step correction of the turn count.
    logic [REM_W-1:0]      s3_rem;
    logic [REM_W:0]        s3_rem_d;
    logic                  s3_ge;
    logic [REM_W-1:0]      s3_sel;

    always_comb
    begin
        s3_rem   = REM_W'({1'b0, v2_reg} - kd2_reg);
        s3_rem_d = {1'b0, s3_rem} - (REM_W+1)'(TWOPI_HI);
        s3_ge    = !s3_rem_d[REM_W];
        s3_sel   = s3_ge ? s3_rem_d[REM_W-1:0] : s3_rem;
    end

    // Stage 5: low-part correction, fold, round to Q.30.
    logic [LO_W:0]         s5_sum;
    logic signed [R_W-1:0] s5_r;
    logic signed [R_W-1:0] s5_f;
    logic [R_W-1:0]        s5_fm;
    logic [R_W-1:0]        s5_xm;
    q30_t                  s5_x;

    always_comb
    begin
        s5_sum = {1'b0, lo4_reg} + (LO_W+1)'(33'h080000000);
        s5_r   = r04_reg - $signed(R_W'(s5_sum[LO_W:32]));
        if (s5_r > HALF_PI_S)
        begin
            s5_f = PI_S - s5_r;
        end
        else if (s5_r < -HALF_PI_S)
        begin
            s5_f = -PI_S - s5_r;
        end
        else
        begin
            s5_f = s5_r;
        end
        s5_fm = s5_f[R_W-1] ? R_W'(-s5_f) : R_W'(s5_f);
        s5_xm = (s5_fm + R_W'(2)) >> 2;
        s5_x  = s5_f[R_W-1] ? -q30_t'(s5_xm[X_W-1:0]) : q30_t'(s5_xm[X_W-1:0]);
    end

    // Valid bits and sign travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{valid: valid_in, neg: s1_neg};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg  <= s1_kprod[61:40];
            v1_reg  <= s1_v;
            k2_reg  <= k1_reg;
            v2_reg  <= v1_reg;
            kd2_reg <= KD_W'(k1_reg) * KD_W'(TWOPI_HI);
            k3_reg  <= s3_ge ? (k2_reg + K_W'(1)) : k2_reg;
            r03_reg <= $signed({1'b0, s3_sel}) - PI_S;
            lo4_reg <= LO_W'(k3_reg) * LO_W'(TWOPI_LO);
            r04_reg <= r03_reg;
            x5_reg  <= s5_x;
        end
    end

    assign ctl_out = ctl5_reg;
    assign x_out   = x5_reg;

    // The corrected remainder lies in [-pi, pi) before the low-part fix.
    `SRP_ASSERT_IMPLIES(a_rem_range, clk, rst_n, ctl3_reg.valid, (r03_reg >= -PI_S) && (r03_reg < TOP_S))
    // The folded argument never exceeds pi/2 in magnitude.
    `SRP_ASSERT_IMPLIES(a_fold_range, clk, rst_n, ctl5_reg.valid, (x5_reg <= X_LIMIT) && (x5_reg >= -X_LIMIT))
    // A stall freezes the stage control.
    `SRP_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(ctl5_reg) && $stable(ctl1_reg))

endmodule

[rtl/core/srp_poly.sv]
// Horner evaluation of the odd Taylor polynomial, one multiplier per stage,
// then rounding, saturation and sign. Depends on srp_pkg and the macro header.
`include "sine_range_reduced_polynomial_assert.svh"

module srp_poly (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  srp_pkg::srp_ctl_t       ctl_in,
    input  srp_pkg::q30_t           x_in,
    output srp_pkg::srp_ctl_t       ctl_out,
    output logic signed [31:0]      y_out
);
    import srp_pkg::*;

    localparam q30_t HORNER_C [2:5] = '{C9_Q30, C7_Q30, C5_Q30, C3_Q30};

    srp_ctl_t              ctl_reg  [0:7];
    prod_t                 prod_reg [0:6];
    q30_t                  x_reg    [0:5];
    q30_t                  x2_reg   [1:4];
    logic signed [OUT_W-1:0] y_reg;

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int i = 1; i < 8; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Square of the argument, then the innermost term.
    q30_t s1_x2;
    assign s1_x2 = rnd_q30(prod_reg[0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= prod_t'(x_in) * prod_t'(x_in);
            x_reg[0]    <= x_in;
            prod_reg[1] <= prod_t'(s1_x2) * prod_t'(C11_Q30);
            x2_reg[1]   <= s1_x2;
            x_reg[1]    <= x_reg[0];
        end
    end

    // Middle Horner steps: add a coefficient, multiply by the square.
    for (genvar i = 2; i <= 5; i++)
    begin : g_horner
        q30_t p;
        assign p = HORNER_C[i] + rnd_q30(prod_reg[i-1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[i] <= prod_t'(x2_reg[i-1]) * prod_t'(p);
                x_reg[i]    <= x_reg[i-1];
            end
        end

        if (i < 5)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x2_reg[i] <= x2_reg[i-1];
                end
            end
        end
    end

    // Last coefficient, then the final multiply by the argument.
    q30_t s6_p;
    assign s6_p = C1_Q30 + rnd_q30(prod_reg[5]);

    // Round, saturate to plus or minus one, apply the sign.
    q30_t s7_y;
    q30_t s7_sat;
    q30_t s7_out;

    always_comb
    begin
        s7_y = rnd_q30(prod_reg[6]);
        if (s7_y > ONE_Q30)
        begin
            s7_sat = ONE_Q30;
        end
        else if (s7_y < -ONE_Q30)
        begin
            s7_sat = -ONE_Q30;
        end
        else
        begin
            s7_sat = s7_y;
        end
        s7_out = ctl_reg[6].neg ? -s7_sat : s7_sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[6] <= prod_t'(x_reg[5]) * prod_t'(s6_p);
            y_reg       <= s7_out[OUT_W-1:0];
        end
    end

    assign ctl_out = ctl_reg[7];
    assign y_out   = y_reg;

    // The square of the argument is never negative.
    `SRP_ASSERT_IMPLIES(a_square_sign, clk, rst_n, ctl_reg[1].valid, x2_reg[1] >= 0)
    // The result is always within plus or minus one.
    `SRP_ASSERT_IMPLIES(a_out_range, clk, rst_n, ctl_reg[7].valid, (y_reg <= ONE_Q30) && (y_reg >= -ONE_Q30))
    // A stall freezes the output stage.
    `SRP_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(ctl_reg[7]) && $stable(y_reg))

endmodule
